[design/dma4_pkg.sv]
// Shared types, codes and constants for the four-channel DMA controller.
// No dependencies; every other design file imports this package.
`timescale 1ns / 1ps

package dma4_pkg;

  // Parameter defaults
  localparam int DEF_NUM_CHANNELS = 4;
  localparam int DEF_COUNT_BITS   = 21;

  // Field widths
  localparam int CHAN_W     = 2;
  localparam int REQ_W      = 4;
  localparam int SRC_REG_W  = 28;
  localparam int IN_DATA_W  = 80;
  localparam int OUT_DATA_W = 112;
  localparam int APB_ADDR_W = 3;

  // Operation codes carried in the input tuser
  typedef enum logic [2:0] {
    FUNC_WR_SRC  = 3'd0,
    FUNC_WR_DST  = 3'd1,
    FUNC_WR_CTRL = 3'd2,
    FUNC_RD_CTRL = 3'd3,
    FUNC_TRIGGER = 3'd4,
    FUNC_STEP    = 3'd5
  } func_e;

  // Configuration register indexes
  localparam logic REG_PROC_SEL = 1'b0;
  localparam logic REG_LEGACY   = 1'b1;

  // Start modes
  localparam logic [2:0] MODE_IMMEDIATE = 3'd0;
  localparam logic [2:0] MODE_SOUND     = 3'd6;
  localparam logic [2:0] MODE_FIFO      = 3'd7;

  // Address control codes
  localparam logic [1:0] ADR_INC    = 2'd0;
  localparam logic [1:0] ADR_DEC    = 2'd1;
  localparam logic [1:0] ADR_FIXED  = 2'd2;
  localparam logic [1:0] ADR_RELOAD = 2'd3;

  // Control register bit positions
  localparam int CTL_DCTL_LO = 21;
  localparam int CTL_SCTL_LO = 23;
  localparam int CTL_REPEAT  = 25;
  localparam int CTL_WORD    = 26;
  localparam int CTL_MODE_LO = 27;
  localparam int CTL_IRQ     = 30;
  localparam int CTL_ENABLE  = 31;

  // Write and read masks
  localparam logic [31:0] MASK_ADDR_FULL   = 32'h0FFF_FFFF;
  localparam logic [31:0] MASK_ADDR_NARROW = 32'h07FF_FFFF;
  localparam logic [31:0] MASK_CTRL_SEC3   = 32'hF7E0_FFFF;
  localparam logic [31:0] MASK_CTRL_SEC    = 32'hF7E0_3FFF;
  localparam logic [31:0] MASK_RD_LEGACY   = 32'hFFFF_0000;

  // Unit sizes in bytes
  localparam logic [31:0] SIZE_WORD = 32'd4;
  localparam logic [31:0] SIZE_HALF = 32'd2;
  localparam int          SOUND_UNITS = 4;

  // Configuration as seen by the channels
  typedef struct packed {
    logic proc_sel;
    logic legacy;
  } cfg_t;

  // One decoded input word
  typedef struct packed {
    func_e             func;
    logic [CHAN_W-1:0] channel;
    logic [31:0]       write_mask;
    logic [31:0]       write_value;
    logic [2:0]        event_mode;
    logic [3:0]        event_channels;
    logic              fifo_half_empty;
  } item_t;

  // One result word
  typedef struct packed {
    logic [31:0]       read_data;
    logic              copy_valid;
    logic [31:0]       copy_source;
    logic [31:0]       copy_dest;
    logic              copy_is_word;
    logic [REQ_W-1:0]  start_request;
    logic              irq_valid;
    logic [CHAN_W-1:0] irq_channel;
    logic              transfer_last;
  } res_t;

endpackage

[design/dma4_cfg.sv]
// APB configuration registers: processor select and legacy mode.
// Depends on dma4_pkg.
`timescale 1ns / 1ps

module dma4_cfg (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [dma4_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready,
  output dma4_pkg::cfg_t                  cfg_o
);
  import dma4_pkg::*;

  logic proc_sel_q, proc_sel_d;
  logic legacy_q, legacy_d;
  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  // Register write decode
  always_comb begin
    proc_sel_d = proc_sel_q;
    legacy_d   = legacy_q;
    if (wr_en) begin
      case (paddr[2])
        REG_PROC_SEL: proc_sel_d = pwdata[0];
        REG_LEGACY:   legacy_d   = pwdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      proc_sel_q <= 1'b0;
      legacy_q   <= 1'b0;
    end else begin
      proc_sel_q <= proc_sel_d;
      legacy_q   <= legacy_d;
    end
  end

  // Readback
  always_comb begin
    case (paddr[2])
      REG_PROC_SEL: prdata = {31'b0, proc_sel_q};
      REG_LEGACY:   prdata = {31'b0, legacy_q};
      default:      prdata = '0;
    endcase
  end

  assign cfg_o.proc_sel = proc_sel_q;
  assign cfg_o.legacy   = legacy_q;

endmodule

[design/dma4_chan.sv]
// One DMA channel: its registers, internal addresses and counters, and its
// share of the result for the word in the input register. Depends on dma4_pkg.
`timescale 1ns / 1ps

module dma4_chan #(
  parameter int IDX        = 0,
  parameter int COUNT_BITS = dma4_pkg::DEF_COUNT_BITS
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            apply_i,  // the word leaves the input register
  input  logic            hit_i,    // word addresses this channel
  input  logic            ev_en_i,  // trigger may start this channel
  input  dma4_pkg::item_t item_i,
  input  dma4_pkg::cfg_t  cfg_i,
  output dma4_pkg::res_t  res_o
);
  import dma4_pkg::*;

  localparam logic [REQ_W-1:0] CH_BIT = (IDX < REQ_W) ? REQ_W'(1 << IDX) : '0;
  localparam bit SOUND_CAP = (IDX == 1) || (IDX == 2);

  logic [SRC_REG_W-1:0]  src_q, src_d;
  logic [SRC_REG_W-1:0]  dst_q, dst_d;
  logic [31:0]           ctrl_q, ctrl_d;
  logic [31:0]           cur_src_q, cur_src_d;
  logic [31:0]           cur_dst_q, cur_dst_d;
  logic [COUNT_BITS-1:0] fifo_q, fifo_d;
  logic [COUNT_BITS-1:0] step_q, step_d;

  logic [31:0]           mask;
  logic [31:0]           new_ctrl;
  logic [2:0]            mode;
  logic [1:0]            dctl;
  logic [1:0]            sctl;
  logic                  sound;
  logic                  word;
  logic [31:0]           sz;
  logic [COUNT_BITS-1:0] units;
  logic [COUNT_BITS-1:0] fifo_mid;
  logic [3:0]            ev_mode;

  assign mode = ctrl_q[CTL_MODE_LO +: 3];
  assign dctl = ctrl_q[CTL_DCTL_LO +: 2];
  assign sctl = ctrl_q[CTL_SCTL_LO +: 2];
  assign ev_mode = cfg_i.proc_sel ? {item_i.event_mode, 1'b0} : {1'b0, item_i.event_mode};

  // Next state and result for this channel
  always_comb begin
    src_d     = src_q;
    dst_d     = dst_q;
    ctrl_d    = ctrl_q;
    cur_src_d = cur_src_q;
    cur_dst_d = cur_dst_q;
    fifo_d    = fifo_q;
    step_d    = step_q;
    res_o     = '0;
    mask      = '0;
    new_ctrl  = ctrl_q;
    sound     = cfg_i.legacy && (mode == MODE_SOUND) && SOUND_CAP;
    word      = sound || ctrl_q[CTL_WORD];
    sz        = word ? SIZE_WORD : SIZE_HALF;
    units     = step_q;
    fifo_mid  = fifo_q;

    if (item_i.func == FUNC_TRIGGER) begin
      if (ev_en_i && ctrl_q[CTL_ENABLE] && ({1'b0, mode} == ev_mode)) begin
        res_o.start_request = CH_BIT;
      end
    end

    if (hit_i) begin
      case (item_i.func)
        FUNC_WR_SRC: begin
          mask  = item_i.write_mask &
                  ((!cfg_i.proc_sel || IDX != 0) ? MASK_ADDR_FULL : MASK_ADDR_NARROW);
          src_d = (src_q & ~mask[SRC_REG_W-1:0]) |
                  (item_i.write_value[SRC_REG_W-1:0] & mask[SRC_REG_W-1:0]);
        end
        FUNC_WR_DST: begin
          mask  = item_i.write_mask &
                  ((!cfg_i.proc_sel || IDX == 3) ? MASK_ADDR_FULL : MASK_ADDR_NARROW);
          dst_d = (dst_q & ~mask[SRC_REG_W-1:0]) |
                  (item_i.write_value[SRC_REG_W-1:0] & mask[SRC_REG_W-1:0]);
        end
        FUNC_WR_CTRL: begin
          mask = item_i.write_mask &
                 (!cfg_i.proc_sel ? 32'hFFFF_FFFF
                                  : ((IDX == 3) ? MASK_CTRL_SEC3 : MASK_CTRL_SEC));
          new_ctrl = (ctrl_q & ~mask) | (item_i.write_value & mask);
          ctrl_d   = new_ctrl;
          if (new_ctrl[CTL_ENABLE] && new_ctrl[CTL_MODE_LO +: 3] == MODE_FIFO &&
              item_i.fifo_half_empty) begin
            res_o.start_request = CH_BIT;
          end
          // enable rising edge reloads the internal registers
          if (!ctrl_q[CTL_ENABLE] && new_ctrl[CTL_ENABLE]) begin
            cur_dst_d = {{(32-SRC_REG_W){1'b0}}, dst_q};
            cur_src_d = {{(32-SRC_REG_W){1'b0}}, src_q};
            fifo_d    = new_ctrl[COUNT_BITS-1:0];
            step_d    = '0;
            if (new_ctrl[CTL_MODE_LO +: 3] == MODE_IMMEDIATE) begin
              res_o.start_request = CH_BIT;
            end
          end
        end
        FUNC_RD_CTRL: begin
          res_o.read_data = ctrl_q & (cfg_i.legacy ? MASK_RD_LEGACY : 32'hFFFF_FFFF);
        end
        FUNC_STEP: begin
          // latch the unit count at the start of a transfer
          if (step_q == '0) begin
            units = sound ? COUNT_BITS'(SOUND_UNITS) : ctrl_q[COUNT_BITS-1:0];
          end
          if (units != '0) begin
            res_o.copy_valid   = 1'b1;
            res_o.copy_source  = cur_src_q;
            res_o.copy_dest    = cur_dst_q;
            res_o.copy_is_word = word;
            case (sctl)
              ADR_INC:   cur_src_d = cur_src_q + sz;
              ADR_FIXED: cur_src_d = cur_src_q;
              default:   cur_src_d = cur_src_q - sz;
            endcase
            if (!sound) begin
              case (dctl)
                ADR_INC, ADR_RELOAD: cur_dst_d = cur_dst_q + sz;
                ADR_DEC:             cur_dst_d = cur_dst_q - sz;
                default:             cur_dst_d = cur_dst_q;
              endcase
            end
            units = units - COUNT_BITS'(1);
            if (mode == MODE_FIFO && fifo_q != '0) begin
              fifo_mid = fifo_q - COUNT_BITS'(1);
            end
          end
          step_d = units;
          fifo_d = fifo_mid;
          // completion rules
          if (units == '0) begin
            res_o.transfer_last = 1'b1;
            if (mode == MODE_FIFO && fifo_mid != '0) begin
              if (item_i.fifo_half_empty) res_o.start_request = CH_BIT;
            end else begin
              if (ctrl_q[CTL_REPEAT] && mode != MODE_IMMEDIATE) begin
                fifo_d = ctrl_q[COUNT_BITS-1:0];
                if (dctl == ADR_RELOAD) cur_dst_d = {{(32-SRC_REG_W){1'b0}}, dst_q};
                if (mode == MODE_FIFO && item_i.fifo_half_empty) begin
                  res_o.start_request = CH_BIT;
                end
              end else begin
                ctrl_d[CTL_ENABLE] = 1'b0;
              end
              res_o.irq_valid = ctrl_q[CTL_IRQ];
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_q     <= '0;
      dst_q     <= '0;
      ctrl_q    <= '0;
      cur_src_q <= '0;
      cur_dst_q <= '0;
      fifo_q    <= '0;
      step_q    <= '0;
    end else if (apply_i) begin
      src_q     <= src_d;
      dst_q     <= dst_d;
      ctrl_q    <= ctrl_d;
      cur_src_q <= cur_src_d;
      cur_dst_q <= cur_dst_d;
      fifo_q    <= fifo_d;
      step_q    <= step_d;
    end
  end

endmodule

[design/four_channel_dma_controller_top.sv]
// Top level of the four-channel DMA controller: input register, channel
// lanes, result register. Depends on dma4_pkg, dma4_cfg and dma4_chan.
//
// Usage:
//   Input stream (s_axis_*): one word per register write, control read,
//   trigger event or transfer step; the operation code travels in tuser.
//   Output stream (m_axis_*): exactly one result word per input word, in
//   order; tlast marks the step that finished a channel's transfer.
//   APB port: processor select at address 0, legacy mode at address 4;
//   write it only while the streams are idle.
// Pipeline: an accepted word is taken into the input register; when the
//   result register is free, it is evaluated against the channel state and
//   stored in the result register.
// Throughput: one word per cycle unless stalled; the channel state is read
//   and updated in the same cycle a word moves from the input register to
//   the result register; consecutive words to a channel follow back to back.
// Reset: all channel registers, counters and configuration clear to zero;
//   both stages come up empty.
// Stall: while m_axis_tready is low the result holds; one more input word
//   is still taken if the input register is empty, then s_axis_tready drops.
`timescale 1ns / 1ps

module four_channel_dma_controller_top #(
  parameter int NUM_CHANNELS = dma4_pkg::DEF_NUM_CHANNELS,
  parameter int COUNT_BITS   = dma4_pkg::DEF_COUNT_BITS
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // input stream
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // channel, write_mask, write_value, event_mode, event_channels,
  // fifo_half_empty (from bit 0 up), zero padded
  input  logic [dma4_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // func
  input  logic [2:0]                      s_axis_tuser,
  // output stream
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // read_data, copy_valid, copy_source, copy_dest, copy_is_word,
  // start_request, irq_valid, irq_channel (from bit 0 up), zero padded
  output logic [dma4_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  // transfer_last
  output logic                            m_axis_tlast,
  // configuration
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [dma4_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);
  import dma4_pkg::*;

  cfg_t  cfg;
  item_t item_q;
  logic  in_valid_q;
  res_t  out_q, out_d;
  logic  out_valid_q;
  logic  advance;
  res_t  lane_res [NUM_CHANNELS];
  logic  [NUM_CHANNELS-1:0] lane_hit;
  logic  [NUM_CHANNELS-1:0] lane_ev;

  dma4_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Handshake: the input register drains when the result register is free
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      item_q.func            <= func_e'(s_axis_tuser);
      item_q.channel         <= s_axis_tdata[1:0];
      item_q.write_mask      <= s_axis_tdata[33:2];
      item_q.write_value     <= s_axis_tdata[65:34];
      item_q.event_mode      <= s_axis_tdata[68:66];
      item_q.event_channels  <= s_axis_tdata[72:69];
      item_q.fifo_half_empty <= s_axis_tdata[73];
    end
  end

  // Channel lanes; only the first four are reachable by the channel field
  for (genvar i = 0; i < NUM_CHANNELS; i++) begin : g_chan
    if (i < REQ_W) begin : g_addr
      assign lane_hit[i] = (item_q.channel == CHAN_W'(i));
      assign lane_ev[i]  = item_q.event_channels[i];
    end else begin : g_none
      assign lane_hit[i] = 1'b0;
      assign lane_ev[i]  = 1'b0;
    end

    dma4_chan #(
      .IDX        (i),
      .COUNT_BITS (COUNT_BITS)
    ) u_chan (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .apply_i (advance),
      .hit_i   (lane_hit[i]),
      .ev_en_i (lane_ev[i]),
      .item_i  (item_q),
      .cfg_i   (cfg),
      .res_o   (lane_res[i])
    );
  end

  // Merge lane results; only the addressed lane drives anything but requests
  always_comb begin
    out_d = '0;
    for (int k = 0; k < NUM_CHANNELS; k++) begin
      out_d = out_d | lane_res[k];
    end
    out_d.irq_channel = out_d.irq_valid ? item_q.channel : '0;
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= out_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tlast  = out_q.transfer_last;
  assign m_axis_tdata  = {7'b0,
                          out_q.irq_channel,
                          out_q.irq_valid,
                          out_q.start_request,
                          out_q.copy_is_word,
                          out_q.copy_dest,
                          out_q.copy_source,
                          out_q.copy_valid,
                          out_q.read_data};

endmodule

[design/dma4_checker.sv]
// Port-level checks for the DMA controller top, attached by bind.
// Depends on dma4_pkg and four_channel_dma_controller_top.
`timescale 1ns / 1ps

module dma4_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [dma4_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input logic                            m_axis_tlast
);
  import dma4_pkg::*;

  // A stalled result word stays offered
  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result word dropped while stalled");

  // An interrupt is only raised on the step that ends a transfer
  a_irq_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[102] |-> m_axis_tlast)
    else $error("interrupt without transfer end");

  // Without a copy the copy fields read zero
  a_copy_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[32] |-> m_axis_tdata[97:33] == '0)
    else $error("copy fields set without a copy");

  // Read data only comes with a control read, never with a copy or an end
  a_read_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[31:0] != '0 |->
      !m_axis_tdata[32] && !m_axis_tlast && !m_axis_tdata[102])
    else $error("read data mixed with step results");

  // Nothing is offered while reset is held
  a_reset_empty: assert property (@(posedge clk_i)
    !rst_ni |=> !m_axis_tvalid || rst_ni)
    else $error("result offered during reset");

endmodule

bind four_channel_dma_controller_top dma4_checker u_dma4_checker (.*);
